// File: src/dri_pkg.sv
`default_nettype none
// Shared types, constants and pipeline latencies of the delta robot inverse kinematics core.
package dri_pkg;

    localparam int IN_W  = 72;
    localparam int OUT_W = 64;

    localparam logic [1:0] REG_BASE_RADIUS      = 2'd0;
    localparam logic [1:0] REG_PLATFORM_RADIUS  = 2'd1;
    localparam logic [1:0] REG_UPPER_ARM_LENGTH = 2'd2;
    localparam logic [1:0] REG_LOWER_ARM_LENGTH = 2'd3;

    localparam logic [15:0] RST_BASE_RADIUS      = 16'd12800;
    localparam logic [15:0] RST_PLATFORM_RADIUS  = 16'd2880;
    localparam logic [15:0] RST_UPPER_ARM_LENGTH = 16'd22400;
    localparam logic [15:0] RST_LOWER_ARM_LENGTH = 16'd51200;

    localparam logic [17:0] PI_Q16      = 18'd205887;
    localparam logic [17:0] HALF_PI_Q16 = 18'd102944;
    localparam logic [14:0] WRIST_MAX   = 15'd25736;

    localparam logic [15:0] ATAN_Q16 [16] = '{
        16'd51472, 16'd30386, 16'd16055, 16'd8150, 16'd4091, 16'd2047, 16'd1024, 16'd512,
        16'd256, 16'd128, 16'd64, 16'd32, 16'd16, 16'd8, 16'd4, 16'd2
    };

    localparam int ACOS_LAT  = 35;
    localparam int ARM_LAT   = 80;
    localparam int FRONT_LAT = 2;
    localparam int WRIST_DLY = FRONT_LAT + ARM_LAT - ACOS_LAT - 1;
    localparam int PIPE_LAT  = FRONT_LAT + ARM_LAT + 1;

    typedef struct packed {
        logic [15:0] base_radius;
        logic [15:0] platform_radius;
        logic [15:0] upper_arm_length;
        logic [15:0] lower_arm_length;
    } dri_cfg_t;

endpackage
`default_nettype wire

// File: src/dri_acos.sv
`default_nettype none
// Pipelined arccosine: square-root stage chain followed by CORDIC vectoring stages.
module dri_acos (
    input  logic               aclk,
    input  logic               ce,
    input  logic signed [16:0] c_i,
    output logic [17:0]        z_o
);
    import dri_pkg::*;

    localparam int RW  = 16;
    localparam int NW  = 2 * RW;
    localparam int NIT = 16;
    localparam int XW  = 31;
    localparam int ZW  = 19;

    logic signed [16:0] c_reg;
    logic signed [33:0] c2_reg;
    logic signed [33:0] c2;
    logic signed [33:0] rad_full;

    assign c2 = c_i * c_i;

    always_ff @(posedge aclk) begin
        if (ce) begin
            c_reg  <= c_i;
            c2_reg <= c2;
        end
    end

    assign rad_full = 34'sd1073741824 - c2_reg;

    logic [NW-1:0]      sq_rad_reg  [RW];
    logic [RW+1:0]      sq_rem_reg  [RW];
    logic [RW-1:0]      sq_root_reg [RW];
    logic signed [16:0] sq_c_reg    [RW];

    for (genvar i = 0; i < RW; i++) begin : g_sq
        logic [NW-1:0]      rad_s;
        logic [RW+1:0]      rem_s;
        logic [RW-1:0]      root_s;
        logic signed [16:0] c_s;
        logic [RW+3:0]      shifted;
        logic [RW+3:0]      trial;
        logic [RW+3:0]      diff;
        logic               ge;
        if (i == 0) begin : g_first
            assign rad_s  = rad_full[NW-1:0];
            assign rem_s  = '0;
            assign root_s = '0;
            assign c_s    = c_reg;
        end else begin : g_next
            assign rad_s  = sq_rad_reg[i-1];
            assign rem_s  = sq_rem_reg[i-1];
            assign root_s = sq_root_reg[i-1];
            assign c_s    = sq_c_reg[i-1];
        end
        assign shifted = {rem_s, rad_s[NW-1 -: 2]};
        assign trial   = {2'b00, root_s, 2'b01};
        assign diff    = shifted - trial;
        assign ge      = shifted >= trial;
        always_ff @(posedge aclk) begin
            if (ce) begin
                sq_rad_reg[i]  <= {rad_s[NW-3:0], 2'b00};
                sq_rem_reg[i]  <= ge ? diff[RW+1:0] : shifted[RW+1:0];
                sq_root_reg[i] <= {root_s[RW-2:0], ge};
                sq_c_reg[i]    <= c_s;
            end
        end
    end

    logic [RW-1:0]         s_fin;
    logic signed [16:0]    c_fin;
    logic signed [16:0]    negc;
    logic signed [XW-1:0]  x0_reg;
    logic signed [XW-1:0]  y0_reg;
    logic signed [ZW-1:0]  z0_reg;

    assign s_fin = sq_root_reg[RW-1];
    assign c_fin = sq_c_reg[RW-1];
    assign negc  = -c_fin;

    always_ff @(posedge aclk) begin
        if (ce) begin
            if (c_fin >= 0) begin
                x0_reg <= XW'(c_fin) <<< 12;
                y0_reg <= $signed(XW'({s_fin, 12'b0}));
                z0_reg <= '0;
            end else begin
                x0_reg <= $signed(XW'({s_fin, 12'b0}));
                y0_reg <= XW'(negc) <<< 12;
                z0_reg <= $signed(ZW'(HALF_PI_Q16));
            end
        end
    end

    logic signed [XW-1:0] cx_reg [NIT];
    logic signed [XW-1:0] cy_reg [NIT];
    logic signed [ZW-1:0] cz_reg [NIT];

    for (genvar i = 0; i < NIT; i++) begin : g_cordic
        logic signed [XW-1:0] xs;
        logic signed [XW-1:0] ys;
        logic signed [ZW-1:0] zs;
        logic signed [ZW-1:0] at;
        if (i == 0) begin : g_first
            assign xs = x0_reg;
            assign ys = y0_reg;
            assign zs = z0_reg;
        end else begin : g_next
            assign xs = cx_reg[i-1];
            assign ys = cy_reg[i-1];
            assign zs = cz_reg[i-1];
        end
        assign at = $signed(ZW'(ATAN_Q16[i]));
        always_ff @(posedge aclk) begin
            if (ce) begin
                if (ys > 0) begin
                    cx_reg[i] <= xs + (ys >>> i);
                    cy_reg[i] <= ys - (xs >>> i);
                    cz_reg[i] <= zs + at;
                end else begin
                    cx_reg[i] <= xs - (ys >>> i);
                    cy_reg[i] <= ys + (xs >>> i);
                    cz_reg[i] <= zs - at;
                end
            end
        end
    end

    logic signed [ZW-1:0] z_fin;
    assign z_fin = cz_reg[NIT-1];

    always_ff @(posedge aclk) begin
        if (ce) begin
            if (z_fin < 0) begin
                z_o <= '0;
            end else if (z_fin > $signed(ZW'(PI_Q16))) begin
                z_o <= PI_Q16;
            end else begin
                z_o <= z_fin[17:0];
            end
        end
    end

endmodule
`default_nettype wire

// File: src/dri_arm.sv
`default_nettype none
// One arm solver: squared distances, square root, two cosine dividers and two arccosines.
module dri_arm (
    input  logic                aclk,
    input  logic                ce,
    input  dri_pkg::dri_cfg_t   cfg_i,
    input  logic signed [19:0]  u_i,
    input  logic signed [19:0]  v_i,
    input  logic signed [17:0]  z_i,
    output logic signed [15:0]  angle_o,
    output logic                bad_o
);
    import dri_pkg::*;

    localparam int RW = 23;
    localparam int NW = 2 * RW;
    localparam int QW = 16;

    // stage 1: squares
    logic signed [20:0] dx;
    logic signed [41:0] dx2;
    logic signed [35:0] z2;
    logic signed [39:0] v2;
    logic [31:0]        ll;
    logic [31:0]        uu;
    logic [37:0]        dx2_reg;
    logic [34:0]        z2_reg;
    logic [35:0]        v2_reg;
    logic [31:0]        ll_reg;
    logic [31:0]        uu_reg;
    logic signed [20:0] na_reg;

    assign dx  = $signed(21'(u_i)) - $signed({5'b0, cfg_i.base_radius});
    assign dx2 = dx * dx;
    assign z2  = z_i * z_i;
    assign v2  = v_i * v_i;
    assign ll  = cfg_i.lower_arm_length * cfg_i.lower_arm_length;
    assign uu  = cfg_i.upper_arm_length * cfg_i.upper_arm_length;

    always_ff @(posedge aclk) begin
        if (ce) begin
            dx2_reg <= dx2[37:0];
            z2_reg  <= z2[34:0];
            v2_reg  <= v2[35:0];
            ll_reg  <= ll;
            uu_reg  <= uu;
            na_reg  <= -dx;
        end
    end

    // stage 2: distance squared, lower arm and degenerate geometry checks
    logic [37:0]        ad2_sum;
    logic [37:0]        ad2_reg;
    logic signed [37:0] cdn_reg;
    logic signed [20:0] na2_reg;
    logic               bad2_reg;

    assign ad2_sum = dx2_reg + 38'(z2_reg);

    always_ff @(posedge aclk) begin
        if (ce) begin
            ad2_reg  <= ad2_sum;
            cdn_reg  <= $signed(38'(v2_reg)) - $signed(38'(ll_reg));
            na2_reg  <= na_reg;
            bad2_reg <= (v2_reg > 36'(ll_reg)) || (cfg_i.base_radius == '0) ||
                        (cfg_i.upper_arm_length == '0) || (ad2_sum == '0);
        end
    end

    // square root of ad2 * 256
    logic signed [39:0] num0;
    assign num0 = $signed({8'b0, uu_reg}) + $signed({2'b0, ad2_reg}) + 40'(cdn_reg);

    logic [NW-1:0]      sq_rad_reg  [RW];
    logic [RW+1:0]      sq_rem_reg  [RW];
    logic [RW-1:0]      sq_root_reg [RW];
    logic signed [39:0] sq_num_reg  [RW];
    logic signed [20:0] sq_na_reg   [RW];
    logic               sq_bad_reg  [RW];

    for (genvar i = 0; i < RW; i++) begin : g_sq
        logic [NW-1:0]      rad_s;
        logic [RW+1:0]      rem_s;
        logic [RW-1:0]      root_s;
        logic signed [39:0] num_s;
        logic signed [20:0] na_s;
        logic               bad_s;
        logic [RW+3:0]      shifted;
        logic [RW+3:0]      trial;
        logic [RW+3:0]      diff;
        logic               ge;
        if (i == 0) begin : g_first
            assign rad_s  = {ad2_reg, 8'b0};
            assign rem_s  = '0;
            assign root_s = '0;
            assign num_s  = num0;
            assign na_s   = na2_reg;
            assign bad_s  = bad2_reg;
        end else begin : g_next
            assign rad_s  = sq_rad_reg[i-1];
            assign rem_s  = sq_rem_reg[i-1];
            assign root_s = sq_root_reg[i-1];
            assign num_s  = sq_num_reg[i-1];
            assign na_s   = sq_na_reg[i-1];
            assign bad_s  = sq_bad_reg[i-1];
        end
        assign shifted = {rem_s, rad_s[NW-1 -: 2]};
        assign trial   = {2'b00, root_s, 2'b01};
        assign diff    = shifted - trial;
        assign ge      = shifted >= trial;
        always_ff @(posedge aclk) begin
            if (ce) begin
                sq_rad_reg[i]  <= {rad_s[NW-3:0], 2'b00};
                sq_rem_reg[i]  <= ge ? diff[RW+1:0] : shifted[RW+1:0];
                sq_root_reg[i] <= {root_s[RW-2:0], ge};
                sq_num_reg[i]  <= num_s;
                sq_na_reg[i]   <= na_s;
                sq_bad_reg[i]  <= bad_s;
            end
        end
    end

    // divider operands
    logic [RW-1:0]      ad4;
    logic signed [39:0] num_f;
    logic signed [20:0] na_f;
    logic [39:0]        db;
    logic [20:0]        na_mag;
    logic [39:0]        num_mag;
    logic [39:0]        pa_n_reg;
    logic [57:0]        pb_n_reg;
    logic [RW-1:0]      pa_d_reg;
    logic [39:0]        pb_d_reg;
    logic               p_sa_reg;
    logic               p_sb_reg;
    logic               p_bad_reg;

    assign ad4     = sq_root_reg[RW-1];
    assign num_f   = sq_num_reg[RW-1];
    assign na_f    = sq_na_reg[RW-1];
    assign db      = {cfg_i.upper_arm_length, 1'b0} * ad4;
    assign na_mag  = na_f[20] ? 21'(-na_f) : 21'(na_f);
    assign num_mag = num_f[39] ? 40'(-num_f) : 40'(num_f);

    always_ff @(posedge aclk) begin
        if (ce) begin
            pa_n_reg  <= {na_mag[20:0], 19'b0};
            pb_n_reg  <= {num_mag[38:0], 19'b0};
            pa_d_reg  <= ad4;
            pb_d_reg  <= db;
            p_sa_reg  <= na_f[20];
            p_sb_reg  <= num_f[39];
            p_bad_reg <= sq_bad_reg[RW-1];
        end
    end

    // quotient range check
    logic [39:0]   oa_n_reg;
    logic [57:0]   ob_n_reg;
    logic [RW-1:0] oa_d_reg;
    logic [39:0]   ob_d_reg;
    logic          o_sa_reg;
    logic          o_sb_reg;
    logic          o_bad_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            oa_n_reg  <= pa_n_reg;
            ob_n_reg  <= pb_n_reg;
            oa_d_reg  <= pa_d_reg;
            ob_d_reg  <= pb_d_reg;
            o_sa_reg  <= p_sa_reg;
            o_sb_reg  <= p_sb_reg;
            o_bad_reg <= p_bad_reg || (pa_n_reg >= 40'({pa_d_reg, 16'b0})) ||
                         (pb_n_reg >= 58'({pb_d_reg, 16'b0}));
        end
    end

    // restoring dividers, one quotient bit per stage
    logic [39:0]   ra_reg  [QW];
    logic [57:0]   rb_reg  [QW];
    logic [QW-1:0] qa_reg  [QW];
    logic [QW-1:0] qb_reg  [QW];
    logic [RW-1:0] da_reg  [QW];
    logic [39:0]   dbp_reg [QW];
    logic          sa_reg  [QW];
    logic          sb_reg  [QW];
    logic          dbad_reg [QW];

    for (genvar i = 0; i < QW; i++) begin : g_div
        localparam int K = QW - 1 - i;
        logic [39:0]   ra_s;
        logic [57:0]   rb_s;
        logic [QW-1:0] qa_s;
        logic [QW-1:0] qb_s;
        logic [RW-1:0] da_s;
        logic [39:0]   db_s;
        logic          sa_s;
        logic          sb_s;
        logic          bad_s;
        logic [39:0]   dsa;
        logic [57:0]   dsb;
        logic          gea;
        logic          geb;
        if (i == 0) begin : g_first
            assign ra_s  = oa_n_reg;
            assign rb_s  = ob_n_reg;
            assign qa_s  = '0;
            assign qb_s  = '0;
            assign da_s  = oa_d_reg;
            assign db_s  = ob_d_reg;
            assign sa_s  = o_sa_reg;
            assign sb_s  = o_sb_reg;
            assign bad_s = o_bad_reg;
        end else begin : g_next
            assign ra_s  = ra_reg[i-1];
            assign rb_s  = rb_reg[i-1];
            assign qa_s  = qa_reg[i-1];
            assign qb_s  = qb_reg[i-1];
            assign da_s  = da_reg[i-1];
            assign db_s  = dbp_reg[i-1];
            assign sa_s  = sa_reg[i-1];
            assign sb_s  = sb_reg[i-1];
            assign bad_s = dbad_reg[i-1];
        end
        assign dsa = 40'(da_s) << K;
        assign dsb = 58'(db_s) << K;
        assign gea = ra_s >= dsa;
        assign geb = rb_s >= dsb;
        always_ff @(posedge aclk) begin
            if (ce) begin
                ra_reg[i]   <= gea ? ra_s - dsa : ra_s;
                rb_reg[i]   <= geb ? rb_s - dsb : rb_s;
                qa_reg[i]   <= {qa_s[QW-2:0], gea};
                qb_reg[i]   <= {qb_s[QW-2:0], geb};
                da_reg[i]   <= da_s;
                dbp_reg[i]  <= db_s;
                sa_reg[i]   <= sa_s;
                sb_reg[i]   <= sb_s;
                dbad_reg[i] <= bad_s;
            end
        end
    end

    // signed cosines
    logic [QW-1:0]      qa_f;
    logic [QW-1:0]      qb_f;
    logic signed [16:0] ca_reg;
    logic signed [16:0] cb_reg;
    logic               q_bad_reg;

    assign qa_f = qa_reg[QW-1];
    assign qb_f = qb_reg[QW-1];

    always_ff @(posedge aclk) begin
        if (ce) begin
            ca_reg    <= sa_reg[QW-1] ? -$signed({1'b0, qa_f}) : $signed({1'b0, qa_f});
            cb_reg    <= sb_reg[QW-1] ? -$signed({1'b0, qb_f}) : $signed({1'b0, qb_f});
            q_bad_reg <= dbad_reg[QW-1] || (qa_f > 16'd32768) || (qb_f > 16'd32768);
        end
    end

    logic [17:0] ang_a;
    logic [17:0] ang_b;

    dri_acos u_acos_a (
        .aclk (aclk),
        .ce   (ce),
        .c_i  (ca_reg),
        .z_o  (ang_a)
    );

    dri_acos u_acos_b (
        .aclk (aclk),
        .ce   (ce),
        .c_i  (cb_reg),
        .z_o  (ang_b)
    );

    logic [ACOS_LAT-1:0] bad_pipe_reg;

    always_ff @(posedge aclk) begin
        if (ce) begin
            bad_pipe_reg <= {bad_pipe_reg[ACOS_LAT-2:0], q_bad_reg};
        end
    end

    // pi - A - B, rounded to Q3.13
    logic signed [19:0] angle;
    logic signed [19:0] angle_rnd;

    assign angle     = $signed({2'b0, PI_Q16}) - $signed({2'b0, ang_a}) - $signed({2'b0, ang_b});
    assign angle_rnd = angle + 20'sd4;

    always_ff @(posedge aclk) begin
        if (ce) begin
            angle_o <= angle_rnd[18:3];
            bad_o   <= bad_pipe_reg[ACOS_LAT-1];
        end
    end

endmodule
`default_nettype wire

// File: src/delta_robot_inverse_kinematics_core.sv
`default_nettype none
// Delta robot inverse kinematics core, fully pipelined.
// Throughput is one word per cycle while the output is not stalled.
// Depth is set by the 23-stage square root, 16-stage dividers and the 35-stage arccosine.
// A stalled output freezes the whole pipeline; nothing is dropped or repeated.
// aresetn (synchronous, active low) clears all valid bits and loads the default geometry.
module delta_robot_inverse_kinematics_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // pos_x[17:0], pos_y[35:18], pos_z[53:36], rot_r11[69:54]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,   // arm1[15:0], arm2[31:16], arm3[47:32], wrist[62:48]
    output logic        m_tuser,   // unreachable
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [15:0] cfg_wdata
);
    import dri_pkg::*;

    localparam logic signed [17:0] SIN120 = 18'sd56756;

    dri_cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.base_radius      <= RST_BASE_RADIUS;
            cfg_reg.platform_radius  <= RST_PLATFORM_RADIUS;
            cfg_reg.upper_arm_length <= RST_UPPER_ARM_LENGTH;
            cfg_reg.lower_arm_length <= RST_LOWER_ARM_LENGTH;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_BASE_RADIUS:      cfg_reg.base_radius      <= cfg_wdata;
                REG_PLATFORM_RADIUS:  cfg_reg.platform_radius  <= cfg_wdata;
                REG_UPPER_ARM_LENGTH: cfg_reg.upper_arm_length <= cfg_wdata;
                REG_LOWER_ARM_LENGTH: cfg_reg.lower_arm_length <= cfg_wdata;
                default: ;
            endcase
        end
    end

    logic                ce;
    logic [PIPE_LAT-1:0] vld_reg;

    assign m_tvalid = vld_reg[PIPE_LAT-1];
    assign ce       = !m_tvalid || m_tready;
    assign s_tready = ce;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (ce) begin
            vld_reg <= {vld_reg[PIPE_LAT-2:0], s_tvalid};
        end
    end

    // stage 1: rotation products
    logic signed [17:0] in_x;
    logic signed [17:0] in_y;
    logic signed [17:0] in_z;
    logic signed [15:0] in_r11;
    logic signed [35:0] sx;
    logic signed [35:0] sy;
    logic signed [17:0] x_reg;
    logic signed [17:0] y_reg;
    logic signed [17:0] z1_reg;
    logic signed [35:0] sx_reg;
    logic signed [35:0] sy_reg;

    assign in_x   = s_tdata[17:0];
    assign in_y   = s_tdata[35:18];
    assign in_z   = s_tdata[53:36];
    assign in_r11 = s_tdata[69:54];
    assign sx     = in_x * SIN120;
    assign sy     = in_y * SIN120;

    always_ff @(posedge aclk) begin
        if (ce) begin
            x_reg  <= in_x;
            y_reg  <= in_y;
            z1_reg <= in_z;
            sx_reg <= sx;
            sy_reg <= sy;
        end
    end

    // stage 2: radial and tangential parts per arm
    logic signed [37:0] xh;
    logic signed [37:0] yh;
    logic signed [37:0] rr;
    logic signed [37:0] sxe;
    logic signed [37:0] sye;
    logic signed [37:0] u2s;
    logic signed [37:0] v2s;
    logic signed [37:0] u3s;
    logic signed [37:0] v3s;
    logic signed [19:0] u_reg [3];
    logic signed [19:0] v_reg [3];
    logic signed [17:0] z2_reg;

    assign xh  = 38'(x_reg) <<< 15;
    assign yh  = 38'(y_reg) <<< 15;
    assign rr  = $signed({6'b0, cfg_reg.platform_radius, 16'b0});
    assign sxe = 38'(sx_reg);
    assign sye = 38'(sy_reg);
    assign u2s = -xh + sye + rr + 38'sd32768;
    assign v2s = -sxe - yh + 38'sd32768;
    assign u3s = -xh - sye + rr + 38'sd32768;
    assign v3s = sxe - yh + 38'sd32768;

    always_ff @(posedge aclk) begin
        if (ce) begin
            u_reg[0] <= $signed(20'(x_reg)) + $signed({4'b0, cfg_reg.platform_radius});
            v_reg[0] <= 20'(y_reg);
            u_reg[1] <= u2s[35:16];
            v_reg[1] <= v2s[35:16];
            u_reg[2] <= u3s[35:16];
            v_reg[2] <= v3s[35:16];
            z2_reg   <= z1_reg;
        end
    end

    logic signed [15:0] arm_angle [3];
    logic [2:0]         arm_bad;

    for (genvar a = 0; a < 3; a++) begin : g_arm
        dri_arm u_arm (
            .aclk    (aclk),
            .ce      (ce),
            .cfg_i   (cfg_reg),
            .u_i     (u_reg[a]),
            .v_i     (v_reg[a]),
            .z_i     (z2_reg),
            .angle_o (arm_angle[a]),
            .bad_o   (arm_bad[a])
        );
    end

    // wrist: delay -r11 to line up with the arms
    logic signed [16:0] wr_reg [WRIST_DLY];

    always_ff @(posedge aclk) begin
        if (ce) begin
            wr_reg[0] <= -$signed(17'(in_r11));
            for (int i = 1; i < WRIST_DLY; i++) begin
                wr_reg[i] <= wr_reg[i-1];
            end
        end
    end

    logic [17:0] wrist_z;
    logic [17:0] wrist_rnd;
    logic [14:0] wrist_reg;

    dri_acos u_acos_wrist (
        .aclk (aclk),
        .ce   (ce),
        .c_i  (wr_reg[WRIST_DLY-1]),
        .z_o  (wrist_z)
    );

    assign wrist_rnd = wrist_z + 18'd4;

    always_ff @(posedge aclk) begin
        if (ce) begin
            wrist_reg <= wrist_rnd[17:3];
        end
    end

    // output word
    logic unreach;
    assign unreach = |arm_bad;

    always_ff @(posedge aclk) begin
        if (ce) begin
            m_tuser <= unreach;
            if (unreach) begin
                m_tdata <= '0;
            end else begin
                m_tdata <= {1'b0, wrist_reg, arm_angle[2], arm_angle[1], arm_angle[0]};
            end
        end
    end

endmodule
`default_nettype wire

// File: src/dri_checker.sv
`default_nettype none
// Port-level checks of the inverse kinematics core and their bind to the top level.
module dri_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic        m_tuser
);
    import dri_pkg::*;

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("output word changed while stalled");

    a_no_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready == (!m_tvalid || m_tready))
        else $error("input stalled while output free");

    a_unreach_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tdata == '0)
        else $error("unreachable word carries nonzero angles");

    a_wrist_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> !m_tdata[63] && (m_tdata[62:48] <= WRIST_MAX))
        else $error("wrist angle out of range");

    a_reset_flush: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

bind delta_robot_inverse_kinematics_core dri_checker u_dri_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);
`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for the delta robot inverse kinematics core.
module testbench;
    import dri_pkg::*;

    localparam int SETTLE_CYCLES = PIPE_LAT + 20;

    typedef struct {
        logic [15:0] arm1;
        logic [15:0] arm2;
        logic [15:0] arm3;
        logic [14:0] wrist;
        logic        unreachable;
    } pose_angles_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [71:0] s_tdata;   // pos_x[17:0], pos_y[35:18], pos_z[53:36], rot_r11[69:54]
    logic        m_tvalid;
    logic        m_tready;
    logic [63:0] m_tdata;   // arm1[15:0], arm2[31:16], arm3[47:32], wrist[62:48]
    logic        m_tuser;   // unreachable
    logic        cfg_wr_en;
    logic [1:0]  cfg_addr;
    logic [15:0] cfg_wdata;

    dri_cfg_t     geom;
    pose_angles_t angle_queue[$];
    int           error_count;
    int           word_count;
    int           unreachable_count;
    int           hold_off_cycles;
    int           rx_gap_cycles;
    bit           rx_random_stall;

    delta_robot_inverse_kinematics_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    initial aclk = 1'b0;
    always #1 aclk = ~aclk;

    // ---------------- predictor ----------------
    function automatic longint floor_shr(longint v, int s);
        if (v >= 0) return v >>> s;
        return -(((-v) + (longint'(1) << s) - 1) >>> s);
    endfunction

    function automatic longint int_sqrt(longint n);
        longint res;
        longint bit_val;
        res = 0;
        bit_val = longint'(1) << 62;
        while (bit_val > n) bit_val = bit_val >>> 2;
        while (bit_val != 0) begin
            if (n >= res + bit_val) begin
                n = n - (res + bit_val);
                res = (res >>> 1) + bit_val;
            end else begin
                res = res >>> 1;
            end
            bit_val = bit_val >>> 2;
        end
        return res;
    endfunction

    function automatic longint arccos_q16(longint c);
        longint s, x, y, z, nx;
        s = int_sqrt((longint'(1) << 30) - c * c);
        if (c >= 0) begin
            x = c * 4096; y = s * 4096; z = 0;
        end else begin
            x = s * 4096; y = -c * 4096; z = HALF_PI_Q16;
        end
        for (int i = 0; i < 16; i++) begin
            if (y > 0) begin
                nx = x + floor_shr(y, i);
                y = y - floor_shr(x, i);
                z = z + ATAN_Q16[i];
            end else begin
                nx = x - floor_shr(y, i);
                y = y + floor_shr(x, i);
                z = z - ATAN_Q16[i];
            end
            x = nx;
        end
        if (z < 0) z = 0;
        if (z > PI_Q16) z = PI_Q16;
        return z;
    endfunction

    function automatic longint round_q13(longint a);
        return floor_shr(a + 4, 3);
    endfunction

    function automatic bit arm_drive_angle(longint x, longint y, longint z, longint ca,
                                           longint sa, output longint angle);
        longint rb, ua, la, u, v, cd2, ad2, ad4, qa, qb, num;
        rb = geom.base_radius;
        ua = geom.upper_arm_length;
        la = geom.lower_arm_length;
        angle = 0;
        u = floor_shr(x * ca + y * sa + (longint'(geom.platform_radius) << 16) + 32768, 16);
        v = floor_shr(-x * sa + y * ca + 32768, 16);
        cd2 = la * la - v * v;
        ad2 = (u - rb) * (u - rb) + z * z;
        if (cd2 < 0 || rb == 0 || ua == 0 || ad2 == 0) return 0;
        ad4 = int_sqrt(ad2 << 8);
        if (ad4 == 0) return 0;
        qa = ((rb - u) * (longint'(1) << 19)) / ad4;
        num = ua * ua + ad2 - cd2;
        qb = (num * (longint'(1) << 19)) / (2 * ua * ad4);
        if (qa > 32768 || qa < -32768 || qb > 32768 || qb < -32768) return 0;
        angle = PI_Q16 - arccos_q16(qa) - arccos_q16(qb);
        return 1;
    endfunction

    function automatic pose_angles_t solve_pose(logic [71:0] word);
        longint x, y, z, r11, a1, a2, a3;
        bit ok;
        pose_angles_t p;
        x = longint'($signed(word[17:0]));
        y = longint'($signed(word[35:18]));
        z = longint'($signed(word[53:36]));
        r11 = longint'($signed(word[69:54]));
        ok = arm_drive_angle(x, y, z, 65536, 0, a1);
        ok = arm_drive_angle(x, y, z, -32768, 56756, a2) && ok;
        ok = arm_drive_angle(x, y, z, -32768, -56756, a3) && ok;
        if (ok) begin
            p.arm1 = 16'(round_q13(a1));
            p.arm2 = 16'(round_q13(a2));
            p.arm3 = 16'(round_q13(a3));
            p.wrist = 15'(round_q13(arccos_q16(-r11)));
            p.unreachable = 1'b0;
        end else begin
            p = '{16'd0, 16'd0, 16'd0, 15'd0, 1'b1};
        end
        return p;
    endfunction

    // ---------------- drivers ----------------
    function automatic int gap_len();
        if ($urandom_range(0, 3) == 0) return 0;
        if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
        return $urandom_range(0, 3);
    endfunction

    // tvalid stays high between back-to-back words; it drops only ahead of a gap
    task automatic send_pose(logic [17:0] x, logic [17:0] y, logic [17:0] z,
                             logic [15:0] r11, bit gaps);
        int g;
        g = gaps ? gap_len() : 0;
        if (g > 0) begin
            s_tvalid <= 1'b0;
            repeat (g) @(posedge aclk);
        end
        s_tdata <= {2'b00, r11, z, y, x};
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        angle_queue.push_back(solve_pose({2'b00, r11, z, y, x}));
    endtask

    task automatic write_reg(logic [1:0] idx, logic [15:0] val);
        cfg_addr <= idx;
        cfg_wdata <= val;
        cfg_wr_en <= 1'b1;
        @(posedge aclk);
        case (idx)
            REG_BASE_RADIUS:      geom.base_radius = val;
            REG_PLATFORM_RADIUS:  geom.platform_radius = val;
            REG_UPPER_ARM_LENGTH: geom.upper_arm_length = val;
            default:              geom.lower_arm_length = val;
        endcase
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (angle_queue.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic set_geometry(logic [15:0] rb, logic [15:0] rp, logic [15:0] ua,
                                logic [15:0] la);
        wait_drained();
        write_reg(REG_BASE_RADIUS, rb);
        write_reg(REG_PLATFORM_RADIUS, rp);
        write_reg(REG_UPPER_ARM_LENGTH, ua);
        write_reg(REG_LOWER_ARM_LENGTH, la);
        cfg_wr_en <= 1'b0;
    endtask

    // mostly reachable poses below the base, some wide random noise
    task automatic send_random_pose();
        logic [17:0] x, y, z;
        if ($urandom_range(0, 3) != 0) begin
            x = 18'($signed($urandom_range(0, 2 * 6400)) - 6400);
            y = 18'($signed($urandom_range(0, 2 * 6400)) - 6400);
            z = 18'(-$signed($urandom_range(20000, 60000)));
        end else begin
            x = 18'($urandom);
            y = 18'($urandom);
            z = 18'($urandom);
        end
        send_pose(x, y, z, 16'($urandom), 1'b1);
    endtask

    // ---------------- result checker ----------------
    always @(posedge aclk) begin
        pose_angles_t exp_p;
        if (aresetn && m_tvalid && m_tready) begin
            if (angle_queue.size() == 0) begin
                $display("%0t: unexpected word %h user %b", $time, m_tdata, m_tuser);
                error_count++;
            end else begin
                exp_p = angle_queue.pop_front();
                word_count++;
                if (m_tuser) unreachable_count++;
                if ({exp_p.wrist, exp_p.arm3, exp_p.arm2, exp_p.arm1} !== m_tdata[62:0]
                    || m_tdata[63] !== 1'b0 || exp_p.unreachable !== m_tuser) begin
                    $display("%0t: mismatch expected arm %h %h %h wrist %h unr %b",
                             $time, exp_p.arm1, exp_p.arm2, exp_p.arm3, exp_p.wrist,
                             exp_p.unreachable);
                    $display("%0t:          actual   arm %h %h %h wrist %h unr %b",
                             $time, m_tdata[15:0], m_tdata[31:16], m_tdata[47:32],
                             m_tdata[62:48], m_tuser);
                    error_count++;
                end
            end
        end
    end

    // receiver stalls, short and occasionally long, plus a long hold-off when requested
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_gap_cycles <= 0;
        end else if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            m_tready <= 1'b0;
        end else if (rx_gap_cycles > 0) begin
            rx_gap_cycles <= rx_gap_cycles - 1;
            m_tready <= 1'b0;
        end else if (rx_random_stall) begin
            if ($urandom_range(0, 49) == 0) begin
                rx_gap_cycles <= $urandom_range(10, 40);
                m_tready <= 1'b0;
            end else begin
                m_tready <= ($urandom_range(0, 3) != 0);
            end
        end else begin
            m_tready <= 1'b1;
        end
    end

    // ---------------- tests ----------------
    task automatic test_directed_reset_geometry();
        send_pose(18'd0, 18'd0, -18'sd38400, 16'h0000, 1'b0);
        send_pose(18'h1FFFF, 18'h1FFFF, 18'h1FFFF, 16'h7FFF, 1'b0);
        send_pose(18'h20000, 18'h20000, 18'h20000, 16'h8000, 1'b0);
        send_pose(18'd0, 18'd0, 18'd0, 16'h8000, 1'b0);
        send_pose(18'd3200, -18'sd1600, -18'sd32000, 16'h4000, 1'b0);
        send_pose(-18'sd3200, 18'd2500, -18'sd45000, 16'hC000, 1'b0);
        send_pose(18'd0, 18'h1FFFF, -18'sd30000, 16'h0001, 1'b0);
        send_pose(18'd9920, 18'd0, 18'd0, 16'hFFFF, 1'b0);
        send_pose(18'd0, 18'd0, -18'sd73000, 16'h1234, 1'b0);
        send_pose(18'h15555, 18'h2AAAA, 18'h15555, 16'h5555, 1'b0);
        send_pose(18'h2AAAA, 18'h15555, 18'h2AAAA, 16'hAAAA, 1'b0);
    endtask

    task automatic test_degenerate_geometry();
        // zero base radius and unit-length arms
        set_geometry(16'd0, 16'd0, 16'd1, 16'd1);
        send_pose(18'd0, 18'd0, -18'sd100, 16'h0000, 1'b0);
        send_pose(18'd0, 18'd0, 18'd0, 16'h7FFF, 1'b0);
        set_geometry(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_pose(18'd0, 18'd0, -18'sd60000, 16'h0000, 1'b0);
        send_pose(18'h1FFFF, 18'h20000, 18'h20000, 16'h8000, 1'b0);
        send_pose(-18'sd65535, 18'd0, 18'd0, 16'h7FFF, 1'b0);
        set_geometry(16'd100, 16'd0, 16'd200, 16'd400);
        send_pose(18'd100, 18'd0, 18'd0, 16'h0000, 1'b0);
        send_pose(18'd0, 18'd0, -18'sd300, 16'h2000, 1'b0);
    endtask

    task automatic test_random_poses(int n);
        for (int i = 0; i < n; i++) send_random_pose();
    endtask

    task automatic test_output_backpressure();
        hold_off_cycles = 400;
        for (int i = 0; i < 200; i++) send_random_pose();
        wait_drained();
        for (int i = 0; i < 40; i++) send_random_pose();
    endtask

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        cfg_wr_en = 1'b0;
        cfg_addr = REG_BASE_RADIUS;
        cfg_wdata = '0;
        hold_off_cycles = 0;
        rx_random_stall = 1'b0;
        error_count = 0;
        word_count = 0;
        unreachable_count = 0;
        geom = '{RST_BASE_RADIUS, RST_PLATFORM_RADIUS, RST_UPPER_ARM_LENGTH,
                 RST_LOWER_ARM_LENGTH};
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed_reset_geometry();
        test_degenerate_geometry();
        set_geometry(RST_BASE_RADIUS, RST_PLATFORM_RADIUS, RST_UPPER_ARM_LENGTH,
                     RST_LOWER_ARM_LENGTH);
        rx_random_stall = 1'b1;
        test_random_poses(500);
        set_geometry(16'd9000, 16'd1500, 16'd18000, 16'd42000);
        test_random_poses(300);
        set_geometry(16'd16000, 16'd4000, 16'd30000, 16'd60000);
        test_random_poses(200);
        set_geometry(RST_BASE_RADIUS, RST_PLATFORM_RADIUS, RST_UPPER_ARM_LENGTH,
                     RST_LOWER_ARM_LENGTH);
        test_output_backpressure();
        rx_random_stall = 1'b0;
        test_random_poses(60);

        wait_drained();
        $display("Checked %0d words (%0d unreachable) over 6 geometries,", word_count,
                 unreachable_count);
        $display("with random gaps on both sides and a long output hold-off.");
        if (error_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("FAIL");
        $finish;
    end

endmodule

// File: filelist.f
src/dri_pkg.sv
src/dri_acos.sv
src/dri_arm.sv
src/delta_robot_inverse_kinematics_core.sv
src/dri_checker.sv
tb/testbench.sv
